// File: hdl/assert_macros.svh
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds in the same cycle whenever the antecedent holds.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Holds in the cycle after the antecedent holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/ssp_pkg.sv
// Types and constants of the stable sorted priority queue.
`default_nettype none
package ssp_pkg;

  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    req_e              req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]   job_id;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [PRIO_W-1:0] out_priority;
    logic [ID_W-1:0]   out_job_id;
    logic [CNT_W-1:0]  count;
  } out_word_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/ssp_cell.sv
// One storage cell of the sorted chain, holding a single queue entry.
`default_nettype none
module ssp_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  wire logic               clk_i,
  input  wire ssp_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [CW-1:0]      count_i,
  input  wire ssp_pkg::entry_t    left_entry_i,
  input  wire logic               left_greater_i,
  input  wire ssp_pkg::entry_t    right_entry_i,
  output ssp_pkg::entry_t         entry_o,
  output logic                    greater_o
);
  import ssp_pkg::*;

  entry_t entry_q;
  entry_t entry_d;
  logic   live;

  assign live      = CW'(IDX) < count_i;
  assign greater_o = !live || (ctrl_i.entry.prio > entry_q.prio);
  assign entry_o   = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (greater_o) begin
        entry_d = left_greater_i ? left_entry_i : ctrl_i.entry;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

// File: hdl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue built as a chain of cells.
`default_nettype none
// The queue holds up to DEPTH entries in a row of cells sorted by descending
// priority, with equal priorities kept in arrival order, and takes one insert
// or remove word per cycle: every cell compares the new priority in parallel
// and shifts toward its neighbor in the same cycle, so each request has its
// result word in the output register in the cycle after it is accepted. The
// input stalls only while a result word waits in that register and the
// output side stalls. The capacity register may be written at any time the
// queue is idle; values above DEPTH act as DEPTH.
module stable_sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [ssp_pkg::CAP_W-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire ssp_pkg::in_word_t        in_word_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output ssp_pkg::out_word_t            out_word_o
);
  import ssp_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    count_d;
  logic             out_valid_q;
  out_word_t        out_word_q;
  out_word_t        out_word_d;

  logic       accept;
  logic       full;
  logic       empty;
  logic       do_ins;
  logic       do_rem;
  cell_ctrl_t ctrl;

  entry_t entry_w   [DEPTH];
  logic   greater_w [DEPTH];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign full        = (XW'(count_q) >= XW'(cap_q)) || (XW'(count_q) >= XW'(DEPTH));
  assign empty       = (count_q == '0);
  assign do_ins      = accept && (in_word_i.req_type == REQ_INSERT) && !full;
  assign do_rem      = accept && (in_word_i.req_type == REQ_REMOVE) && !empty;

  assign ctrl.ins        = do_ins;
  assign ctrl.rem        = do_rem;
  assign ctrl.entry.prio = in_word_i.priority_req;
  assign ctrl.entry.id   = in_word_i.job_id;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    logic   left_greater;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_entry   = '0;
      assign left_greater = 1'b0;
    end else begin : g_inner_left
      assign left_entry   = entry_w[i-1];
      assign left_greater = greater_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner_right
      assign right_entry = entry_w[i+1];
    end

    ssp_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_entry_i  (left_entry),
      .left_greater_i(left_greater),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[i]),
      .greater_o     (greater_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_rem) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    out_word_d              = '0;
    out_word_d.count        = CNT_W'(count_d);
    if (in_word_i.req_type == REQ_INSERT) begin
      out_word_d.status = full ? ST_FULL : ST_DONE;
    end else if (empty) begin
      out_word_d.status = ST_EMPTY;
    end else begin
      out_word_d.status       = ST_DONE;
      out_word_d.out_priority = entry_w[0].prio;
      out_word_d.out_job_id   = entry_w[0].id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

// File: hdl/ssp_checker.sv
// Port-level checker of the stable sorted priority queue and its bind.
`default_nettype none
`include "assert_macros.svh"
module ssp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire ssp_pkg::out_word_t out_word_o
);
  import ssp_pkg::*;

  `ASSERT_NEXT(a_accept_gives_word, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)
  `ASSERT_SAME(a_stall_only_when_held, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `ASSERT_SAME(a_empty_word_zero, clk_i, rst_ni, out_valid_o && out_word_o.status == ST_EMPTY, out_word_o.count == '0 && out_word_o.out_priority == '0 && out_word_o.out_job_id == '0)
  `ASSERT_NEXT(a_stalled_word_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))

endmodule

bind stable_sorted_priority_queue ssp_checker u_ssp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);
`default_nettype wire
